// ===== rtl/core/demand_paged_search_frame_manager_assert.svh =====
// assertion macros for the frame manager rtl
// used by the top level
`ifndef DEMAND_PAGED_SEARCH_FRAME_MANAGER_ASSERT_SVH
`define DEMAND_PAGED_SEARCH_FRAME_MANAGER_ASSERT_SVH
// assert that a implies b in the same cycle
`define DPS_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b in the next cycle
`define DPS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/dpsfm_pkg.sv =====
// shared types and constants for the frame manager
// no dependencies
package dpsfm_pkg;
	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_LOAD = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_PROBE_WAIT,
		ST_PROBE_EVAL,
		ST_POP_WAIT,
		ST_LOAD,
		ST_LOAD_WAIT,
		ST_REL,
		ST_REL_EVAL,
		ST_DONE
	} state_t;

	localparam int FRAME_W = 14;
	localparam int ENTRY_W = FRAME_W + 1;
	localparam logic signed [9:0] ACTIVE_LOW_RESET = 10'sd501;
endpackage

// ===== rtl/core/dpsfm_page_ram.sv =====
// page table memory, registered read
// depends on dpsfm_pkg
module dpsfm_page_ram #(
	parameter int DEPTH = 32768,
	parameter int AW = 15
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [dpsfm_pkg::ENTRY_W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [dpsfm_pkg::ENTRY_W-1:0] rdata
);
	import dpsfm_pkg::*;
	logic [ENTRY_W-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/dpsfm_free_ram.sv =====
// free frame fifo storage, registered read
// depends on dpsfm_pkg
module dpsfm_free_ram #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [dpsfm_pkg::FRAME_W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [dpsfm_pkg::FRAME_W-1:0] rdata
);
	import dpsfm_pkg::*;
	logic [FRAME_W-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/demand_paged_search_frame_manager.sv =====
// frame manager top: control sequencer over page table and free fifo memories
// an item is accepted in idle and ends in done; a search runs probe, probe wait and
// probe eval per probe, plus pop wait on a fault; a load runs load and load wait
// per page; a release runs rel and rel eval per page table entry; one item at a
// time, and a new item is taken in the cycle the last result item leaves; after reset
// a clearing pass fills both memories while no item is taken
module demand_paged_search_frame_manager #(
	parameter int NUM_PROCS = 16,
	parameter int PAGES_PER_PROC = 2048,
	parameter int NUM_FRAMES = 4096,
	parameter int FRAME_BASE = 4096,
	parameter int WORDS_PER_PAGE = 1024,
	parameter int RESIDENT_PAGES = 10
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] mode,
	input logic [3:0] process,
	input logic [20:0] array_size,
	input logic signed [31:0] key,
	output logic out_valid,
	input logic out_ready,
	output logic signed [21:0] found_index,
	output logic swapped_out,
	output logic load_failed,
	output logic [31:0] total_accesses,
	output logic [31:0] total_faults,
	output logic [31:0] total_swaps,
	output logic signed [5:0] active_count,
	output logic signed [9:0] min_active
);
	import dpsfm_pkg::*;
	`include "demand_paged_search_frame_manager_assert.svh"

	localparam int PW = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
	localparam int PRW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int PDEPTH = NUM_PROCS * PAGES_PER_PROC;
	localparam int PAW = $clog2(PDEPTH);
	localparam int FAW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FCW = $clog2(NUM_FRAMES + 1);
	localparam int CLRW = $clog2(((PDEPTH > NUM_FRAMES) ? PDEPTH : NUM_FRAMES) + 1);
	localparam int CLRN = (PDEPTH > NUM_FRAMES) ? PDEPTH : NUM_FRAMES;
	localparam int RPW = $clog2(RESIDENT_PAGES + 1);

	state_t state_q, state_d;
	logic [CLRW-1:0] clr_q;
	logic [PRW-1:0] proc_q;
	logic signed [22:0] left_q, right_q;
	logic signed [32:0] key_q;
	logic [PW-1:0] page_q;
	logic [RPW-1:0] idx_q;
	logic [FAW-1:0] head_q;
	logic [FCW-1:0] count_q;
	logic [31:0] acc_q, flt_q, swp_q;
	logic signed [5:0] act_q;
	logic signed [9:0] low_q;
	logic swap_q, rel_swap_q, lfail_q;
	logic [1:0] mode_q;

	logic p_we, f_we;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [ENTRY_W-1:0] p_wdata, p_rdata;
	logic [FAW-1:0] f_waddr, f_raddr;
	logic [FRAME_W-1:0] f_wdata, f_rdata;

	dpsfm_page_ram #(.DEPTH(PDEPTH), .AW(PAW)) u_page (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));
	dpsfm_free_ram #(.DEPTH(NUM_FRAMES), .AW(FAW)) u_free (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata));

	logic signed [22:0] mid;
	logic [22:0] mid_u;
	logic [PW-1:0] probe_page;
	logic [PAW-1:0] base_addr;
	logic [FCW:0] tail_sum;
	logic [FAW-1:0] tail_idx;
	logic out_free;
	logic signed [6:0] act_dec;

	always_comb begin
		mid = (left_q + right_q) >>> 1;
		mid_u = mid;
		// page number; mid is never negative inside the loop
		probe_page = PW'((RESIDENT_PAGES + (mid_u / WORDS_PER_PAGE)) % PAGES_PER_PROC);
		base_addr = PAW'(proc_q) * PAW'(PAGES_PER_PROC);
		tail_sum = (FCW+1)'(head_q) + (FCW+1)'(count_q);
		tail_idx = (tail_sum >= (FCW+1)'(NUM_FRAMES)) ?
			FAW'(tail_sum - (FCW+1)'(NUM_FRAMES)) : FAW'(tail_sum);
		out_free = !out_valid || out_ready;
		act_dec = (act_q == -6'sd32) ? 7'(act_q) : 7'(act_q) - 7'sd1;
	end

	assign in_ready = (state_q == ST_IDLE) && out_free;

	always_comb begin
		state_d = state_q;
		p_we = 1'b0;
		p_waddr = base_addr + PAW'(page_q);
		p_wdata = '0;
		p_raddr = base_addr + PAW'(page_q);
		f_we = 1'b0;
		f_waddr = tail_idx;
		f_wdata = p_rdata[FRAME_W-1:0];
		f_raddr = head_q;
		case (state_q)
			ST_CLEAR: begin
				p_we = (clr_q < CLRW'(PDEPTH));
				p_waddr = PAW'(clr_q);
				f_we = (clr_q < CLRW'(NUM_FRAMES));
				f_waddr = FAW'(clr_q);
				f_wdata = FRAME_W'(FRAME_BASE + int'(clr_q));
				if (clr_q == CLRW'(CLRN - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (mode_t'(mode))
						MODE_SEARCH: state_d = ST_PROBE;
						MODE_LOAD: state_d = ST_LOAD;
						MODE_RELEASE: state_d = ST_REL;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PROBE: begin
				p_raddr = base_addr + PAW'(probe_page);
				state_d = (left_q < right_q) ? ST_PROBE_WAIT : ST_DONE;
			end
			ST_PROBE_WAIT: state_d = ST_PROBE_EVAL;
			ST_PROBE_EVAL: begin
				if (p_rdata[FRAME_W]) state_d = ST_PROBE;
				else if (count_q != '0) state_d = ST_POP_WAIT;
				else state_d = ST_REL;
			end
			ST_POP_WAIT: begin
				p_we = 1'b1;
				p_wdata = {1'b1, f_rdata};
				state_d = ST_PROBE;
			end
			ST_LOAD: begin
				if (lfail_q || idx_q == RPW'(RESIDENT_PAGES)) state_d = ST_DONE;
				else state_d = ST_LOAD_WAIT;
			end
			ST_LOAD_WAIT: begin
				p_we = 1'b1;
				p_wdata = {1'b1, f_rdata};
				state_d = ST_LOAD;
			end
			ST_REL: state_d = ST_REL_EVAL;
			ST_REL_EVAL: begin
				p_we = 1'b1;
				p_wdata = '0;
				f_we = p_rdata[FRAME_W] && (count_q < FCW'(NUM_FRAMES));
				if (page_q == PW'(PAGES_PER_PROC - 1)) state_d = ST_DONE;
				else state_d = ST_REL;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			head_q <= '0;
			count_q <= FCW'(NUM_FRAMES);
			acc_q <= '0;
			flt_q <= '0;
			swp_q <= '0;
			act_q <= '0;
			low_q <= ACTIVE_LOW_RESET;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_PROBE: if (left_q < right_q) acc_q <= (acc_q == '1) ? acc_q : acc_q + 1;
				ST_PROBE_EVAL: if (!p_rdata[FRAME_W]) begin
					flt_q <= (flt_q == '1) ? flt_q : flt_q + 1;
					if (count_q == '0) begin
						swp_q <= (swp_q == '1) ? swp_q : swp_q + 1;
					end
				end
				ST_POP_WAIT: begin
					head_q <= (head_q == FAW'(NUM_FRAMES - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				ST_LOAD: if (!lfail_q && idx_q != RPW'(RESIDENT_PAGES)) begin
					head_q <= (head_q == FAW'(NUM_FRAMES - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				ST_REL_EVAL: begin
					if (p_rdata[FRAME_W] && (count_q < FCW'(NUM_FRAMES)))
						count_q <= count_q + 1'b1;
					if (page_q == PW'(PAGES_PER_PROC - 1)) begin
						act_q <= 6'(act_dec);
						if (rel_swap_q && 10'(act_dec) < low_q) low_q <= 10'(act_dec);
					end
				end
				ST_DONE: begin
					out_valid <= 1'b1;
					if (mode_q == MODE_LOAD) act_q <= (act_q == 6'sd31) ? act_q : act_q + 6'sd1;
				end
				default: ;
			endcase
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				mode_q <= mode;
				proc_q <= PRW'(process % NUM_PROCS);
				left_q <= '0;
				right_q <= 23'(array_size) - 23'sd1;
				key_q <= 33'(key);
				page_q <= '0;
				idx_q <= '0;
				swap_q <= 1'b0;
				rel_swap_q <= 1'b0;
				lfail_q <= (mode == MODE_LOAD) && (count_q < FCW'(RESIDENT_PAGES));
			end
			ST_PROBE: page_q <= probe_page;
			ST_PROBE_EVAL: begin
				if (p_rdata[FRAME_W] || count_q != '0) begin
					if (!p_rdata[FRAME_W]) ; // update after the pop
					else if (key_q <= 33'(mid)) right_q <= mid;
					else left_q <= mid + 23'sd1;
				end else begin
					swap_q <= 1'b1;
					rel_swap_q <= 1'b1;
					page_q <= '0;
				end
			end
			ST_POP_WAIT: begin
				if (key_q <= 33'(mid)) right_q <= mid;
				else left_q <= mid + 23'sd1;
			end
			ST_LOAD: page_q <= PW'(idx_q % PAGES_PER_PROC);
			ST_LOAD_WAIT: idx_q <= idx_q + 1'b1;
			ST_REL_EVAL: page_q <= page_q + 1'b1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			found_index <= (mode_q == MODE_SEARCH) ? (swap_q ? -22'sd1 : 22'(right_q)) : '0;
			swapped_out <= swap_q;
			load_failed <= (mode_q == MODE_LOAD) && lfail_q;
		end
	end

	assign total_accesses = acc_q;
	assign total_faults = flt_q;
	assign total_swaps = swp_q;
	assign active_count = act_q;
	assign min_active = low_q;

	`DPS_ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`DPS_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= FCW'(NUM_FRAMES))
	`DPS_ASSERT_NEXT(a_done_out, clk, arst_n, state_q == ST_DONE, out_valid)
endmodule
